FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Types and constants shared by the chip-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [11:0] PROGRAM_START = 12'h200;
  localparam logic [11:0] PC_STEP       = 12'h002;

  localparam logic [3:0] V0_IDX = 4'h0;
  localparam logic [3:0] VF_IDX = 4'hF;

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;

  // 8xyN operations
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic empty;
    logic full;
  } c8ie_stk_t;

  typedef struct packed {
    logic        vx_we;
    logic [3:0]  vx_addr;
    logic [7:0]  vx_data;
    logic        vf_we;
    logic        vf_data;
    logic        push;
    logic        pop;
    logic [11:0] pc;
    logic [11:0] index;
    logic        clear_request;
    logic        draw_request;
    logic [7:0]  draw_col;
    logic [7:0]  draw_row;
    logic [3:0]  draw_height;
    logic        stack_error;
  } c8ie_exec_t;

endpackage

FILE: src/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes one chip-8 opcode per transaction and reports pc, index and the
// clear, draw and stack error requests.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   opcode, random_byte
//  out      out_valid / out_ready pc_out, index_out, clear_request, draw_request,
//                                 draw_col, draw_row, draw_height, stack_error
//
// one opcode per cycle while the output does not stall: operands are read from
// the register file into the input register, and the opcode then executes from
// the input register into the output register
// a stalled output holds the input register; in_ready drops only then
// synchronous reset: V registers zero, index zero, pc 0x200, stack empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chip8_instruction_execute import c8ie_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] opcode,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] pc_out,
  output logic [11:0] index_out,
  output logic        clear_request,
  output logic        draw_request,
  output logic [7:0]  draw_col,
  output logic [7:0]  draw_row,
  output logic [3:0]  draw_height,
  output logic        stack_error
);

  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // input register
  logic        in_valid_q;
  logic [15:0] op_q;
  logic [7:0]  rnd_q;
  logic [7:0]  x_alt_q, y_alt_q;
  logic        x_use_q, y_use_q;
  logic [7:0]  x_mem_q, y_mem_q;

  logic in_fire, fire;

  // architectural state
  logic [7:0]  vmem [16];
  logic [15:0] vbit;
  logic [7:0]  v0, v0_next;
  logic [7:0]  vf, vf_next;
  logic [11:0] pc, index;
  logic [SW-1:0] sp, sp_next;
  logic [11:0] top, second;
  logic [11:0] smem [STACK_DEPTH];

  c8ie_exec_t upd;
  c8ie_stk_t  stk;
  logic [7:0] vx, vy;
  logic       mem_we;
  logic       push_wr;
  logic [AW-1:0] s_waddr, s_raddr;

  logic [3:0] ax, ay;
  logic       x_hit, y_hit;
  logic [7:0] x_alt, y_alt;
  logic       x_use, y_use;

  assign fire     = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || fire;
  assign in_fire  = in_valid && in_ready;

  assign vx = x_use_q ? x_mem_q : x_alt_q;
  assign vy = y_use_q ? y_mem_q : y_alt_q;

  assign stk.empty = (sp == '0);
  assign stk.full  = (sp == SW'(STACK_DEPTH));

  c8ie_exec u_exec (
    .opcode      (op_q),
    .random_byte (rnd_q),
    .vx          (vx),
    .vy          (vy),
    .v0          (v0),
    .pc          (pc),
    .index       (index),
    .top         (top),
    .stk         (stk),
    .upd         (upd)
  );

  // register file writes: entries 0 and 15 live in flops, the rest in vmem
  assign mem_we = fire && upd.vx_we && (upd.vx_addr != V0_IDX) && (upd.vx_addr != VF_IDX);

  always_comb begin
    v0_next = v0;
    vf_next = vf;
    if (fire && upd.vx_we && upd.vx_addr == V0_IDX) v0_next = upd.vx_data;
    if (fire && upd.vx_we && upd.vx_addr == VF_IDX) vf_next = upd.vx_data;
    // flag is written after vx
    if (fire && upd.vf_we) vf_next = {7'h00, upd.vf_data};
  end

  // operand prefetch for the incoming transaction, forwarding this cycle's write
  assign ax = opcode[11:8];
  assign ay = opcode[7:4];

  always_comb begin
    x_hit = mem_we && (upd.vx_addr == ax);
    y_hit = mem_we && (upd.vx_addr == ay);
    if (x_hit)              x_alt = upd.vx_data;
    else if (ax == V0_IDX)  x_alt = v0_next;
    else if (ax == VF_IDX)  x_alt = vf_next;
    else                    x_alt = 8'h00;
    if (y_hit)              y_alt = upd.vx_data;
    else if (ay == V0_IDX)  y_alt = v0_next;
    else if (ay == VF_IDX)  y_alt = vf_next;
    else                    y_alt = 8'h00;
    x_use = !x_hit && (ax != V0_IDX) && (ax != VF_IDX) && vbit[ax];
    y_use = !y_hit && (ay != V0_IDX) && (ay != VF_IDX) && vbit[ay];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= opcode;
      rnd_q   <= random_byte;
      x_alt_q <= x_alt;
      y_alt_q <= y_alt;
      x_use_q <= x_use;
      y_use_q <= y_use;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) vmem[upd.vx_addr] <= upd.vx_data;
    if (in_fire) begin
      x_mem_q <= vmem[ax];
      y_mem_q <= vmem[ay];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit  <= '0;
      v0    <= 8'h00;
      vf    <= 8'h00;
      pc    <= PROGRAM_START;
      index <= 12'h000;
      sp    <= '0;
    end else begin
      if (mem_we) vbit[upd.vx_addr] <= 1'b1;
      v0 <= v0_next;
      vf <= vf_next;
      sp <= sp_next;
      if (fire) begin
        pc    <= upd.pc;
        index <= upd.index;
      end
    end
  end

  // return stack: top in a flop, entry below it prefetched from smem
  always_comb begin
    sp_next = sp;
    if (fire && upd.push)     sp_next = sp + 1'b1;
    else if (fire && upd.pop) sp_next = sp - 1'b1;
  end

  assign push_wr = fire && upd.push && !stk.empty;
  assign s_waddr = AW'(sp - 1'b1);
  assign s_raddr = (sp_next >= SW'(2)) ? AW'(sp_next - SW'(2)) : '0;

  always_ff @(posedge clk) begin
    if (push_wr) smem[s_waddr] <= top;
    if (push_wr && s_raddr == s_waddr) second <= top;
    else                               second <= smem[s_raddr];
    if (fire && upd.push)     top <= pc;
    else if (fire && upd.pop) top <= second;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pc_out        <= upd.pc;
      index_out     <= upd.index;
      clear_request <= upd.clear_request;
      draw_request  <= upd.draw_request;
      draw_col      <= upd.draw_col;
      draw_row      <= upd.draw_row;
      draw_height   <= upd.draw_height;
      stack_error   <= upd.stack_error;
    end
  end

  `ASSERT_ALWAYS(a_sp_bound, sp <= SW'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_NEXT(a_err_pc_hold, fire && upd.stack_error, pc == $past(pc), "pc moved on stack error")
  `ASSERT_NEXT(a_push_top, fire && upd.push, top == $past(pc) && sp == $past(sp) + 1'b1, "bad push")
  `ASSERT_NEXT(a_stall_hold, in_valid_q && !fire, in_valid_q && $stable(op_q), "input lost on stall")

endmodule

FILE: src/c8ie_exec.sv
// ----------------------------------------------------------------------------
// c8ie_exec
// Decode and execute of one opcode against the current register state.
// ----------------------------------------------------------------------------
module c8ie_exec import c8ie_pkg::*; (
  input  logic [15:0] opcode,
  input  logic [7:0]  random_byte,
  input  logic [7:0]  vx,
  input  logic [7:0]  vy,
  input  logic [7:0]  v0,
  input  logic [11:0] pc,
  input  logic [11:0] index,
  input  logic [11:0] top,
  input  c8ie_stk_t   stk,
  output c8ie_exec_t  upd
);

  logic [3:0]  grp;
  logic [3:0]  n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc_skip;
  logic [8:0]  sum;
  logic [7:0]  vx_plus_kk;

  assign grp        = opcode[15:12];
  assign n          = opcode[3:0];
  assign kk         = opcode[7:0];
  assign nnn        = opcode[11:0];
  assign pc_skip    = pc + PC_STEP;
  assign sum        = {1'b0, vx} + {1'b0, vy};
  assign vx_plus_kk = vx + kk;

  always_comb begin
    upd               = '0;
    upd.vx_addr       = opcode[11:8];
    upd.pc            = pc;
    upd.index         = index;
    priority if (opcode == OPC_CLS) begin
      upd.clear_request = 1'b1;
    end else if (opcode == OPC_RET) begin
      if (stk.empty) begin
        upd.stack_error = 1'b1;
      end else begin
        upd.pop = 1'b1;
        upd.pc  = top;
      end
    end else begin
      unique case (grp)
        GRP_JP: upd.pc = nnn;
        GRP_CALL: begin
          if (stk.full) begin
            upd.stack_error = 1'b1;
          end else begin
            upd.push = 1'b1;
            upd.pc   = nnn;
          end
        end
        GRP_SE:   if (vx == kk) upd.pc = pc_skip;
        GRP_SNE:  if (vx != kk) upd.pc = pc_skip;
        GRP_SER:  if (vx == vy) upd.pc = pc_skip;
        GRP_SNER: if (vx != vy) upd.pc = pc_skip;
        GRP_LD: begin
          upd.vx_we   = 1'b1;
          upd.vx_data = kk;
        end
        GRP_ADD: begin
          upd.vx_we   = 1'b1;
          upd.vx_data = vx_plus_kk;
        end
        GRP_ALU: begin
          unique case (n)
            ALU_LD:  begin upd.vx_we = 1'b1; upd.vx_data = vy; end
            ALU_OR:  begin upd.vx_we = 1'b1; upd.vx_data = vx | vy; end
            ALU_AND: begin upd.vx_we = 1'b1; upd.vx_data = vx & vy; end
            ALU_XOR: begin upd.vx_we = 1'b1; upd.vx_data = vx ^ vy; end
            ALU_ADD: begin
              upd.vx_we = 1'b1; upd.vx_data = sum[7:0];
              upd.vf_we = 1'b1; upd.vf_data = sum[8];
            end
            ALU_SUB: begin
              upd.vx_we = 1'b1; upd.vx_data = vx - vy;
              upd.vf_we = 1'b1; upd.vf_data = vx > vy;
            end
            ALU_SHR: begin
              upd.vx_we = 1'b1; upd.vx_data = {1'b0, vx[7:1]};
              upd.vf_we = 1'b1; upd.vf_data = vx[0];
            end
            ALU_SUBN: begin
              upd.vx_we = 1'b1; upd.vx_data = vy - vx;
              upd.vf_we = 1'b1; upd.vf_data = vy > vx;
            end
            ALU_SHL: begin
              upd.vx_we = 1'b1; upd.vx_data = {vx[6:0], 1'b0};
              upd.vf_we = 1'b1; upd.vf_data = vx[7];
            end
            default: ;
          endcase
        end
        GRP_LDI:  upd.index = nnn;
        GRP_JPV0: upd.pc = nnn + {4'h0, v0};
        GRP_RND: begin
          upd.vx_we   = 1'b1;
          upd.vx_data = random_byte & kk;
        end
        GRP_DRW: begin
          upd.draw_request = 1'b1;
          upd.draw_col     = vx;
          upd.draw_row     = vy;
          upd.draw_height  = n;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: test/tb_chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute
// Self-checking bench for the chip-8 instruction execute block. A directed
// table covers each opcode group but 7xkk, the flag ops, address wrap and a
// return on an empty stack. Random opcodes follow, with call and return
// bursts, while both channels idle at random up to the last third. Each
// result is checked against its row or a bench model of V, index, pc, stack.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_execute;
  import c8ie_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIRECTED_ROWS = 28;

  // groups the block leaves alone
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  typedef struct packed {
    logic [11:0] pc;
    logic [11:0] index;
    logic        clear_request;
    logic        draw_request;
    logic [7:0]  draw_col;
    logic [7:0]  draw_row;
    logic [3:0]  draw_height;
    logic        stack_error;
  } exec_result_t;

  typedef struct {
    logic [15:0]  op;
    logic [7:0]   rnd;
    bit           typed;
    exec_result_t res;
  } stim_row_t;

  localparam exec_result_t NO_CHECK = '0;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] opcode;
  logic [7:0]  random_byte;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] pc_out;
  logic [11:0] index_out;
  logic        clear_request;
  logic        draw_request;
  logic [7:0]  draw_col;
  logic [7:0]  draw_row;
  logic [3:0]  draw_height;
  logic        stack_error;

  // architectural state as the bench sees it
  logic [7:0]  v_file [16];
  logic [11:0] i_reg;
  logic [11:0] pc_reg;
  logic [11:0] call_stack [STACK_DEPTH];
  int          stack_count;

  exec_result_t expected_results [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OPC_CLS, 8'h00, 1'b1, {12'h200, 12'h000, 1'b1, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0}},
    // return on an empty stack
    '{OPC_RET, 8'h00, 1'b1, {12'h200, 12'h000, 1'b0, 1'b0, 8'h00, 8'h00, 4'h0, 1'b1}},
    '{{GRP_LDI, 12'hFFF}, 8'h00, 1'b1,
      {12'h200, 12'hFFF, 1'b0, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0}},
    '{{GRP_JP, 12'hFFF}, 8'h00, 1'b1,
      {12'hFFF, 12'hFFF, 1'b0, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0}},
    // skip taken at the top of the address space wraps
    '{{GRP_SE, 4'h0, 8'h00}, 8'h00, 1'b1,
      {12'h001, 12'hFFF, 1'b0, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0}},
    '{{GRP_LD, 4'h0, 8'hFF}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h0, 4'h0, ALU_ADD}, 8'h00, 1'b0, NO_CHECK},
    // vf as destination, flag overwrites sum
    '{{GRP_ALU, 4'hF, 4'hF, ALU_ADD}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h0, 4'h1, ALU_SUB}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h0, 4'h1, ALU_SUBN}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h0, 4'h0, ALU_SHR}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h0, 4'h0, ALU_SHL}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h1, 4'h0, ALU_OR}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h1, 4'hF, ALU_AND}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h2, 4'h0, ALU_XOR}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_ALU, 4'h3, 4'h2, ALU_LD}, 8'h00, 1'b0, NO_CHECK},
    // undefined alu op
    '{{GRP_ALU, 4'h3, 4'h0, 4'h8}, 8'h00, 1'b0, NO_CHECK},
    // register compares ignore the low nibble
    '{{GRP_SER, 4'hA, 4'h5, 4'hF}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_SNER, 4'h0, 4'h1, 4'h2}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_SNE, 4'h1, 8'h00}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_JPV0, 12'hFFF}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_RND, 4'h2, 8'hAA}, 8'hFF, 1'b0, NO_CHECK},
    '{{GRP_DRW, 4'h1, 4'h2, 4'hF}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_CALL, 12'hABC}, 8'h00, 1'b0, NO_CHECK},
    '{OPC_RET, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_SYS, 12'h123}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_KEY, 12'h29E}, 8'h00, 1'b0, NO_CHECK},
    '{{GRP_MISC, 12'h165}, 8'h00, 1'b0, NO_CHECK}
  };

  chip8_instruction_execute #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .random_byte(random_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pc_out(pc_out),
    .index_out(index_out),
    .clear_request(clear_request),
    .draw_request(draw_request),
    .draw_col(draw_col),
    .draw_row(draw_row),
    .draw_height(draw_height),
    .stack_error(stack_error)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // executes one opcode on the bench state and returns what the block reports
  function automatic exec_result_t execute_opcode(input logic [15:0] op, input logic [7:0] rnd);
    exec_result_t r;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [8:0]  sum;
    logic        flag;
    logic        flag_op;
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    kk  = op[7:0];
    nnn = op[11:0];
    r   = '0;
    if (op == OPC_CLS) begin
      r.clear_request = 1'b1;
    end else if (op == OPC_RET) begin
      if (stack_count == 0) begin
        r.stack_error = 1'b1;
      end else begin
        stack_count--;
        pc_reg = call_stack[STACK_AW'(stack_count)];
      end
    end else begin
      case (op[15:12])
        GRP_JP: pc_reg = nnn;
        GRP_CALL: begin
          if (stack_count >= STACK_DEPTH) begin
            r.stack_error = 1'b1;
          end else begin
            call_stack[STACK_AW'(stack_count)] = pc_reg;
            stack_count++;
            pc_reg = nnn;
          end
        end
        GRP_SE:   if (v_file[x] == kk) pc_reg = pc_reg + PC_STEP;
        GRP_SNE:  if (v_file[x] != kk) pc_reg = pc_reg + PC_STEP;
        GRP_SER:  if (v_file[x] == v_file[y]) pc_reg = pc_reg + PC_STEP;
        GRP_SNER: if (v_file[x] != v_file[y]) pc_reg = pc_reg + PC_STEP;
        GRP_LD:   v_file[x] = kk;
        GRP_ADD:  v_file[x] = v_file[x] + kk;
        GRP_ALU: begin
          a       = v_file[x];
          b       = v_file[y];
          flag    = 1'b0;
          flag_op = 1'b1;
          case (n)
            ALU_LD: begin
              v_file[x] = b;
              flag_op = 1'b0;
            end
            ALU_OR: begin
              v_file[x] = a | b;
              flag_op = 1'b0;
            end
            ALU_AND: begin
              v_file[x] = a & b;
              flag_op = 1'b0;
            end
            ALU_XOR: begin
              v_file[x] = a ^ b;
              flag_op = 1'b0;
            end
            ALU_ADD: begin
              sum = {1'b0, a} + {1'b0, b};
              v_file[x] = sum[7:0];
              flag = sum[8];
            end
            ALU_SUB: begin
              v_file[x] = a - b;
              flag = (a > b);
            end
            ALU_SHR: begin
              v_file[x] = a >> 1;
              flag = a[0];
            end
            ALU_SUBN: begin
              v_file[x] = b - a;
              flag = (b > a);
            end
            ALU_SHL: begin
              v_file[x] = a << 1;
              flag = a[7];
            end
            default: flag_op = 1'b0;
          endcase
          // flag is written last so it wins when x is vf
          if (flag_op) v_file[VF_IDX] = {7'b0, flag};
        end
        GRP_LDI:  i_reg = nnn;
        GRP_JPV0: pc_reg = nnn + {4'h0, v_file[V0_IDX]};
        GRP_RND:  v_file[x] = rnd & kk;
        GRP_DRW: begin
          r.draw_request = 1'b1;
          r.draw_col     = v_file[x];
          r.draw_row     = v_file[y];
          r.draw_height  = n;
        end
        default: ;
      endcase
    end
    r.pc    = pc_reg;
    r.index = i_reg;
    return r;
  endfunction

  // mostly well-formed opcodes, skip operands made to compare equal about half the time
  function automatic logic [15:0] random_opcode();
    int          pick;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  grp;
    logic [7:0]  kk;
    logic [15:0] op;
    pick = $urandom_range(99);
    x    = 4'($urandom_range(15));
    y    = 4'($urandom_range(15));
    kk   = 8'($urandom_range(255));
    if (pick < 25) begin
      op = {GRP_ALU, x, y, 4'($urandom_range(15))};
    end else if (pick < 40) begin
      case ($urandom_range(2))
        0:       grp = GRP_LD;
        1:       grp = GRP_ADD;
        default: grp = GRP_RND;
      endcase
      op = {grp, x, kk};
    end else if (pick < 55) begin
      if ($urandom_range(1)) kk = v_file[x];
      if ($urandom_range(1)) y = x;
      case ($urandom_range(3))
        0:       op = {GRP_SE, x, kk};
        1:       op = {GRP_SNE, x, kk};
        2:       op = {GRP_SER, x, y, 4'($urandom_range(15))};
        default: op = {GRP_SNER, x, y, 4'($urandom_range(15))};
      endcase
    end else if (pick < 67) begin
      op = $urandom_range(1) ? {GRP_CALL, 12'($urandom_range(4095))} : OPC_RET;
    end else if (pick < 77) begin
      case ($urandom_range(2))
        0:       grp = GRP_JP;
        1:       grp = GRP_LDI;
        default: grp = GRP_JPV0;
      endcase
      op = {grp, 12'($urandom_range(4095))};
    end else if (pick < 82) begin
      op = {GRP_DRW, x, y, 4'($urandom_range(15))};
    end else if (pick < 85) begin
      op = OPC_CLS;
    end else begin
      op = 16'($urandom_range(65535));
    end
    return op;
  endfunction

  task automatic send_item(input logic [15:0] op, input logic [7:0] rnd, input bit typed,
                           input exec_result_t given);
    exec_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    random_byte <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = execute_opcode(op, rnd);
    expected_results.push_back(typed ? given : predicted);
  endtask

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual pc %0h", $time,
                 pc_out);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("pc_out", want.pc, pc_out);
        check_field("index_out", want.index, index_out);
        check_field("clear_request", 12'(want.clear_request), 12'(clear_request));
        check_field("draw_request", 12'(want.draw_request), 12'(draw_request));
        check_field("draw_col", 12'(want.draw_col), 12'(draw_col));
        check_field("draw_row", 12'(want.draw_row), 12'(draw_row));
        check_field("draw_height", 12'(want.draw_height), 12'(draw_height));
        check_field("stack_error", 12'(want.stack_error), 12'(stack_error));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          burst_left;
    bit          burst_calls;
    logic [15:0] op;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = '0;
    random_byte    = '0;
    mismatch_count = 0;
    send_idle_pct  = 8;
    recv_idle_pct  = 70;
    burst_left     = 0;
    burst_calls    = 1'b0;
    for (int i = 0; i < 16; i++) v_file[4'(i)] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) call_stack[STACK_AW'(i)] = '0;
    i_reg       = '0;
    pc_reg      = PROGRAM_START;
    stack_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].rnd, directed_rows[i].typed,
                directed_rows[i].res);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 8;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // runs of calls or returns long enough to overflow or underflow the stack
      if (burst_left == 0 && $urandom_range(199) == 0) begin
        burst_left  = STACK_DEPTH + 2 + $urandom_range(4);
        burst_calls = 1'($urandom_range(1));
      end
      if (burst_left > 0) begin
        burst_left--;
        op = burst_calls ? {GRP_CALL, 12'($urandom_range(4095))} : OPC_RET;
      end else begin
        op = random_opcode();
      end
      send_item(op, 8'($urandom_range(255)), 1'b0, NO_CHECK);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
